// ----- rtl/core/gscr_pkg.sv -----
package gscr_pkg;

  localparam int unsigned PinCount    = 32;
  localparam int unsigned WindowBytes = 256;
  localparam int unsigned DataW       = 32;
  localparam int unsigned OffW        = 8;
  localparam int unsigned PinSelW     = $clog2(DataW);
  localparam int unsigned CfgIdxW     = 3;

  localparam logic [DataW-1:0] PinMask = {DataW{1'b1}} >> (DataW - PinCount);

  localparam logic [DataW-1:0] WindowBaseRst = 32'h3FF4_4000;
  localparam logic [OffW-1:0]  OutOffRst     = 8'h04;
  localparam logic [OffW-1:0]  OutSetOffRst  = 8'h08;
  localparam logic [OffW-1:0]  OutClrOffRst  = 8'h0C;
  localparam logic [OffW-1:0]  EnOffRst      = 8'h20;
  localparam logic [OffW-1:0]  EnSetOffRst   = 8'h24;
  localparam logic [OffW-1:0]  EnClrOffRst   = 8'h28;
  localparam logic [OffW-1:0]  InOffRst      = 8'h3C;

  typedef enum logic [1:0] {
    ReqRead    = 2'd0,
    ReqWrite   = 2'd1,
    ReqPin     = 2'd2,
    ReqRefresh = 2'd3
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWindowBase = 3'd0,
    CfgOutOff     = 3'd1,
    CfgOutSetOff  = 3'd2,
    CfgOutClrOff  = 3'd3,
    CfgEnOff      = 3'd4,
    CfgEnSetOff   = 3'd5,
    CfgEnClrOff   = 3'd6,
    CfgInOff      = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [DataW-1:0] window_base;
    logic [OffW-1:0]  out_offset;
    logic [OffW-1:0]  out_set_offset;
    logic [OffW-1:0]  out_clear_offset;
    logic [OffW-1:0]  enable_offset;
    logic [OffW-1:0]  enable_set_offset;
    logic [OffW-1:0]  enable_clear_offset;
    logic [OffW-1:0]  in_offset;
  } cfg_t;

  typedef struct packed {
    req_e             req_type;
    logic [DataW-1:0] bus_address;
    logic [DataW-1:0] write_data;
    logic [5:0]       pin_index;
    logic             pin_level;
  } in_item_t;

  typedef struct packed {
    logic             claimed;
    logic [DataW-1:0] read_data;
    logic [DataW-1:0] out_levels;
    logic [DataW-1:0] out_enables;
    logic [DataW-1:0] change_mask;
  } out_item_t;

endpackage

// ----- rtl/core/gscr_cfg.sv -----
module gscr_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [gscr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gscr_pkg::DataW-1:0]    cfg_wdata_i,
  output gscr_pkg::cfg_t                cfg_o
);

  gscr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (gscr_pkg::cfg_idx_e'(cfg_index_i))
        gscr_pkg::CfgWindowBase: cfg_d.window_base         = cfg_wdata_i;
        gscr_pkg::CfgOutOff:     cfg_d.out_offset          = cfg_wdata_i[gscr_pkg::OffW-1:0];
        gscr_pkg::CfgOutSetOff:  cfg_d.out_set_offset      = cfg_wdata_i[gscr_pkg::OffW-1:0];
        gscr_pkg::CfgOutClrOff:  cfg_d.out_clear_offset    = cfg_wdata_i[gscr_pkg::OffW-1:0];
        gscr_pkg::CfgEnOff:      cfg_d.enable_offset       = cfg_wdata_i[gscr_pkg::OffW-1:0];
        gscr_pkg::CfgEnSetOff:   cfg_d.enable_set_offset   = cfg_wdata_i[gscr_pkg::OffW-1:0];
        gscr_pkg::CfgEnClrOff:   cfg_d.enable_clear_offset = cfg_wdata_i[gscr_pkg::OffW-1:0];
        gscr_pkg::CfgInOff:      cfg_d.in_offset           = cfg_wdata_i[gscr_pkg::OffW-1:0];
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_base         <= gscr_pkg::WindowBaseRst;
      cfg_q.out_offset          <= gscr_pkg::OutOffRst;
      cfg_q.out_set_offset      <= gscr_pkg::OutSetOffRst;
      cfg_q.out_clear_offset    <= gscr_pkg::OutClrOffRst;
      cfg_q.enable_offset       <= gscr_pkg::EnOffRst;
      cfg_q.enable_set_offset   <= gscr_pkg::EnSetOffRst;
      cfg_q.enable_clear_offset <= gscr_pkg::EnClrOffRst;
      cfg_q.in_offset           <= gscr_pkg::InOffRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/gscr_exec.sv -----
module gscr_exec (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 exec_i,
  input  gscr_pkg::in_item_t   item_i,
  input  gscr_pkg::cfg_t       cfg_i,
  output gscr_pkg::out_item_t  result_o
);

  logic [gscr_pkg::DataW-1:0] lvl_q, lvl_d;
  logic [gscr_pkg::DataW-1:0] en_q, en_d;
  logic [gscr_pkg::DataW-1:0] ext_q, ext_d;
  logic [gscr_pkg::DataW-1:0] last_lvl_q, last_lvl_d;
  logic [gscr_pkg::DataW-1:0] last_en_q, last_en_d;
  logic                       primed_q, primed_d;

  logic [gscr_pkg::DataW-1:0] offset;
  logic                       in_window;
  logic                       do_report;
  logic [gscr_pkg::DataW-1:0] changed;
  logic                       claimed;
  logic [gscr_pkg::DataW-1:0] rdata;

  function automatic logic off_hit(input logic [gscr_pkg::DataW-1:0] off,
                                   input logic [gscr_pkg::OffW-1:0]  reg_off);
    off_hit = (off == {{(gscr_pkg::DataW-gscr_pkg::OffW){1'b0}}, reg_off});
  endfunction

  assign offset    = item_i.bus_address - cfg_i.window_base;
  assign in_window = offset < gscr_pkg::DataW'(gscr_pkg::WindowBytes);

  always_comb begin
    lvl_d     = lvl_q;
    en_d      = en_q;
    ext_d     = ext_q;
    claimed   = 1'b0;
    rdata     = '0;
    do_report = 1'b0;
    unique case (item_i.req_type)
      gscr_pkg::ReqRead: begin
        if (in_window) begin
          claimed = 1'b1;
          priority if (off_hit(offset, cfg_i.out_offset)) begin
            rdata = lvl_q;
          end else if (off_hit(offset, cfg_i.enable_offset)) begin
            rdata = en_q;
          end else if (off_hit(offset, cfg_i.in_offset)) begin
            rdata = (lvl_q & en_q) | (ext_q & ~en_q);
          end else begin
            rdata = '0;
          end
        end
      end
      gscr_pkg::ReqWrite: begin
        if (in_window) begin
          claimed   = 1'b1;
          do_report = 1'b1;
          priority if (off_hit(offset, cfg_i.out_offset)) begin
            lvl_d = item_i.write_data;
          end else if (off_hit(offset, cfg_i.out_set_offset)) begin
            lvl_d = lvl_q | item_i.write_data;
          end else if (off_hit(offset, cfg_i.out_clear_offset)) begin
            lvl_d = lvl_q & ~item_i.write_data;
          end else if (off_hit(offset, cfg_i.enable_offset)) begin
            en_d = item_i.write_data;
          end else if (off_hit(offset, cfg_i.enable_set_offset)) begin
            en_d = en_q | item_i.write_data;
          end else if (off_hit(offset, cfg_i.enable_clear_offset)) begin
            en_d = en_q & ~item_i.write_data;
          end else begin
            do_report = 1'b0;
          end
        end
      end
      gscr_pkg::ReqPin: begin
        if ({26'b0, item_i.pin_index} < gscr_pkg::DataW'(gscr_pkg::PinCount)) begin
          ext_d[item_i.pin_index[gscr_pkg::PinSelW-1:0]] = item_i.pin_level;
        end
      end
      gscr_pkg::ReqRefresh: begin
        do_report = 1'b1;
      end
      default: begin
        do_report = 1'b0;
      end
    endcase
  end

  always_comb begin
    last_lvl_d = last_lvl_q;
    last_en_d  = last_en_q;
    primed_d   = primed_q;
    changed    = '0;
    if (do_report) begin
      changed    = primed_q ? ((lvl_d ^ last_lvl_q) | (en_d & ~last_en_q))
                            : {gscr_pkg::DataW{1'b1}};
      changed    = changed & en_d & gscr_pkg::PinMask;
      last_lvl_d = lvl_d;
      last_en_d  = en_d;
      primed_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q      <= '0;
      en_q       <= '0;
      ext_q      <= '0;
      last_lvl_q <= '0;
      last_en_q  <= '0;
      primed_q   <= 1'b0;
    end else if (exec_i) begin
      lvl_q      <= lvl_d;
      en_q       <= en_d;
      ext_q      <= ext_d;
      last_lvl_q <= last_lvl_d;
      last_en_q  <= last_en_d;
      primed_q   <= primed_d;
    end
  end

  assign result_o.claimed     = claimed;
  assign result_o.read_data   = rdata;
  assign result_o.out_levels  = lvl_d;
  assign result_o.out_enables = en_d;
  assign result_o.change_mask = changed;

endmodule

// ----- rtl/core/gpio_set_clear_register_block_unit.sv -----
// Channel  Direction  Handshake           Payload
// in       input      in_valid_i/in_stall_o   gscr_pkg::in_item_t
// out      output     out_valid_o/out_stall_i gscr_pkg::out_item_t
// cfg      input      cfg_we_i            cfg_index_i, cfg_wdata_i
//
// One item per cycle sustained while the output is not stalled.
// The input register feeds the state update and result logic, which loads the output register.
// in_stall_o rises only when the input register holds an item and the output register is
// full and stalled. Reset clears valid flags and GPIO state, loads base and offset defaults.
module gpio_set_clear_register_block_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  gscr_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output gscr_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [gscr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gscr_pkg::DataW-1:0]    cfg_wdata_i
);

  gscr_pkg::cfg_t      cfg;
  gscr_pkg::in_item_t  item_q;
  gscr_pkg::out_item_t result;
  gscr_pkg::out_item_t out_q;
  logic                item_valid_q;
  logic                out_valid_q;
  logic                advance;
  logic                in_xfer;

  assign advance    = item_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = item_valid_q && !advance;
  assign in_xfer    = in_valid_i && !in_stall_o;

  gscr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  gscr_exec u_exec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .exec_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= in_xfer || (item_valid_q && !advance);
      out_valid_q  <= advance || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_item_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- rtl/core/gscr_checker.sv -----
module gscr_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_o,
  input  logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  gscr_pkg::out_item_t  out_item_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.change_mask & ~out_item_o.out_enables) == '0)
    else $error("change mask reports a disabled pin");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.claimed |-> out_item_o.read_data == '0)
    else $error("read data on an unclaimed result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result without a matching input transfer");

endmodule

bind gpio_set_clear_register_block_unit gscr_checker u_gscr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

// ----- verif/gpio_response_checker.sv -----
`timescale 1ns / 1ps

module gpio_response_checker
  import gscr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  in_item_t             in_item_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  out_item_t            out_item_i,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_index_i,
  input  logic [DataW-1:0]     cfg_wdata_i,
  output int                   mismatch_count_o,
  output int                   pending_o
);

  cfg_t             cfg;
  logic [DataW-1:0] drive_level;
  logic [DataW-1:0] drive_enable;
  logic [DataW-1:0] pin_latch;
  logic [DataW-1:0] reported_level;
  logic [DataW-1:0] reported_enable;
  logic             report_armed;
  out_item_t        expected_responses[$];
  out_item_t        want;

  task automatic report_mismatch(string what, logic [DataW-1:0] exp_val,
                                 logic [DataW-1:0] got_val);
    $display("%0t: mismatch on %s: expected %h, got %h", $time, what, exp_val, got_val);
    mismatch_count_o++;
  endtask

  task automatic enqueue_response(out_item_t r);
    expected_responses = {expected_responses, r};
  endtask

  function automatic logic [DataW-1:0] take_change_report();
    logic [DataW-1:0] changed;
    changed = report_armed ? ((drive_level ^ reported_level) |
                              (drive_enable & ~reported_enable)) : '1;
    reported_level  = drive_level;
    reported_enable = drive_enable;
    report_armed    = 1'b1;
    return changed & drive_enable & PinMask;
  endfunction

  function automatic out_item_t predict_gpio_response(in_item_t it);
    out_item_t        res;
    logic [DataW-1:0] offset;
    logic             in_window;
    logic             hit;
    res       = '0;
    offset    = it.bus_address - cfg.window_base;
    in_window = offset < WindowBytes;
    case (it.req_type)
      ReqRead: begin
        if (in_window) begin
          res.claimed = 1'b1;
          if (offset == cfg.out_offset) res.read_data = drive_level;
          else if (offset == cfg.enable_offset) res.read_data = drive_enable;
          else if (offset == cfg.in_offset)
            res.read_data = (drive_level & drive_enable) | (pin_latch & ~drive_enable);
        end
      end
      ReqWrite: begin
        if (in_window) begin
          res.claimed = 1'b1;
          hit = 1'b1;
          if (offset == cfg.out_offset) drive_level = it.write_data;
          else if (offset == cfg.out_set_offset) drive_level |= it.write_data;
          else if (offset == cfg.out_clear_offset) drive_level &= ~it.write_data;
          else if (offset == cfg.enable_offset) drive_enable = it.write_data;
          else if (offset == cfg.enable_set_offset) drive_enable |= it.write_data;
          else if (offset == cfg.enable_clear_offset) drive_enable &= ~it.write_data;
          else hit = 1'b0;
          if (hit) res.change_mask = take_change_report();
        end
      end
      ReqPin: begin
        if (it.pin_index < PinCount) pin_latch[it.pin_index[PinSelW-1:0]] = it.pin_level;
      end
      default: res.change_mask = take_change_report();
    endcase
    res.out_levels  = drive_level;
    res.out_enables = drive_enable;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg = '{WindowBaseRst, OutOffRst, OutSetOffRst, OutClrOffRst,
              EnOffRst, EnSetOffRst, EnClrOffRst, InOffRst};
      drive_level      = '0;
      drive_enable     = '0;
      pin_latch        = '0;
      reported_level   = '0;
      reported_enable  = '0;
      report_armed     = 1'b0;
      expected_responses.delete();
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_responses.size() == 0) begin
          report_mismatch("transfer with nothing pending", '0, out_item_i.read_data);
        end else begin
          want = expected_responses.pop_front();
          if (out_item_i.claimed !== want.claimed)
            report_mismatch("claimed", want.claimed, out_item_i.claimed);
          if (out_item_i.read_data !== want.read_data)
            report_mismatch("read_data", want.read_data, out_item_i.read_data);
          if (out_item_i.out_levels !== want.out_levels)
            report_mismatch("out_levels", want.out_levels, out_item_i.out_levels);
          if (out_item_i.out_enables !== want.out_enables)
            report_mismatch("out_enables", want.out_enables, out_item_i.out_enables);
          if (out_item_i.change_mask !== want.change_mask)
            report_mismatch("change_mask", want.change_mask, out_item_i.change_mask);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CfgWindowBase: cfg.window_base         = cfg_wdata_i;
          CfgOutOff:     cfg.out_offset          = cfg_wdata_i[OffW-1:0];
          CfgOutSetOff:  cfg.out_set_offset      = cfg_wdata_i[OffW-1:0];
          CfgOutClrOff:  cfg.out_clear_offset    = cfg_wdata_i[OffW-1:0];
          CfgEnOff:      cfg.enable_offset       = cfg_wdata_i[OffW-1:0];
          CfgEnSetOff:   cfg.enable_set_offset   = cfg_wdata_i[OffW-1:0];
          CfgEnClrOff:   cfg.enable_clear_offset = cfg_wdata_i[OffW-1:0];
          default:       cfg.in_offset           = cfg_wdata_i[OffW-1:0];
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        enqueue_response(predict_gpio_response(in_item_i));
      end
      pending_o = expected_responses.size();
    end
  end

endmodule

// ----- verif/tb_gpio_set_clear_register_block_unit.sv -----
`timescale 1ns / 1ps

module tb_gpio_set_clear_register_block_unit;
  import gscr_pkg::*;

  localparam int ClkPeriod     = 4;
  localparam int SettleCycles  = 4;
  localparam int LongHold      = 120;
  localparam int WatchdogLimit = 5000;

  localparam cfg_t DefaultCfg = '{WindowBaseRst, OutOffRst, OutSetOffRst, OutClrOffRst,
                                  EnOffRst, EnSetOffRst, EnClrOffRst, InOffRst};

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_item;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [DataW-1:0]   cfg_wdata;

  int   mismatch_count;
  int   responses_pending;
  int   idle_cycles = 0;
  bit   tx_gaps = 1'b0;
  bit   rx_gaps = 1'b0;
  bit   hold_req = 1'b0;
  cfg_t cfg_now = DefaultCfg;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  gpio_set_clear_register_block_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  gpio_response_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_item_i       (out_item),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatch_count),
    .pending_o        (responses_pending)
  );

  always @(negedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic in_item_t make_item(req_e req, logic [DataW-1:0] addr,
                                         logic [DataW-1:0] data, logic [5:0] pin,
                                         logic lvl);
    in_item_t it;
    it.req_type    = req;
    it.bus_address = addr;
    it.write_data  = data;
    it.pin_index   = pin;
    it.pin_level   = lvl;
    return it;
  endfunction

  function automatic logic [DataW-1:0] pick_address();
    logic [OffW-1:0] off;
    int unsigned     r;
    r = $urandom_range(0, 19);
    case ($urandom_range(0, 6))
      0:       off = cfg_now.out_offset;
      1:       off = cfg_now.out_set_offset;
      2:       off = cfg_now.out_clear_offset;
      3:       off = cfg_now.enable_offset;
      4:       off = cfg_now.enable_set_offset;
      5:       off = cfg_now.enable_clear_offset;
      default: off = cfg_now.in_offset;
    endcase
    if (r < 13) return cfg_now.window_base + off;
    if (r < 16) return cfg_now.window_base + $urandom_range(0, WindowBytes - 1);
    if (r == 16) return cfg_now.window_base + WindowBytes + $urandom_range(0, 7);
    if (r == 17) return cfg_now.window_base - 1 - $urandom_range(0, 7);
    return $urandom();
  endfunction

  function automatic in_item_t random_item();
    in_item_t         it;
    logic [DataW-1:0] data;
    int unsigned      r;
    case ($urandom_range(0, 7))
      0:       data = '0;
      1:       data = '1;
      2:       data = 32'h1 << $urandom_range(0, 31);
      default: data = $urandom();
    endcase
    r = $urandom_range(0, 19);
    it = make_item(ReqRefresh, pick_address(), data, 6'($urandom_range(0, 63)),
                   1'($urandom_range(0, 1)));
    if (r < 6) it.req_type = ReqRead;
    else if (r < 13) it.req_type = ReqWrite;
    else if (r < 18) it.req_type = ReqPin;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    bit taken;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do begin
      @(negedge clk_i);
      taken = !in_stall;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (responses_pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_config(cfg_t c);
    logic [DataW-1:0] val;
    cfg_idx_e         idx;
    int               i;
    drain();
    for (i = 0; i < 8; i++) begin
      idx = cfg_idx_e'(i);
      val = $urandom();
      case (idx)
        CfgWindowBase: val           = c.window_base;
        CfgOutOff:     val[OffW-1:0] = c.out_offset;
        CfgOutSetOff:  val[OffW-1:0] = c.out_set_offset;
        CfgOutClrOff:  val[OffW-1:0] = c.out_clear_offset;
        CfgEnOff:      val[OffW-1:0] = c.enable_offset;
        CfgEnSetOff:   val[OffW-1:0] = c.enable_set_offset;
        CfgEnClrOff:   val[OffW-1:0] = c.enable_clear_offset;
        default:       val[OffW-1:0] = c.in_offset;
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= val;
      @(posedge clk_i);
    end
    cfg_we  <= 1'b0;
    cfg_now = c;
  endtask

  task automatic run_random(int count, int hold_at, int pause_at);
    int k;
    for (k = 0; k < count; k++) begin
      if (k == hold_at) hold_req = 1'b1;
      if (k == pause_at) drain();
      send_item(random_item());
    end
  endtask

  function automatic cfg_t random_config();
    cfg_t c;
    c.window_base         = $urandom();
    c.out_offset          = $urandom_range(0, 255);
    c.out_set_offset      = $urandom_range(0, 255);
    c.out_clear_offset    = $urandom_range(0, 255);
    c.enable_offset       = $urandom_range(0, 255);
    c.enable_set_offset   = $urandom_range(0, 255);
    c.enable_clear_offset = $urandom_range(0, 255);
    c.in_offset           = $urandom_range(0, 255);
    return c;
  endfunction

  initial begin
    logic [DataW-1:0] b;
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CfgWindowBase;
    cfg_wdata <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first report after reset covers every enabled pin
    b = cfg_now.window_base;
    send_item(make_item(ReqRead,    b + 'h3C, '0, '0, 1'b0));
    send_item(make_item(ReqWrite,   b + 'h20, 32'hFFFF_FFFF, '0, 1'b0));
    send_item(make_item(ReqWrite,   b + 'h04, 32'hA5A5_A5A5, '0, 1'b0));
    send_item(make_item(ReqWrite,   b + 'h04, 32'hA5A5_A5A5, '0, 1'b0));
    send_item(make_item(ReqWrite,   b + 'h08, 32'h0000_FFFF, '0, 1'b0));
    send_item(make_item(ReqWrite,   b + 'h0C, 32'hFFFF_0000, '0, 1'b0));
    send_item(make_item(ReqWrite,   b + 'h28, 32'h0F0F_0F0F, '0, 1'b0));
    send_item(make_item(ReqWrite,   b + 'h24, 32'h0000_0001, '0, 1'b0));
    send_item(make_item(ReqPin,     '0, '0, 6'd0,  1'b1));
    send_item(make_item(ReqPin,     '0, '0, 6'd31, 1'b1));
    send_item(make_item(ReqPin,     '0, '0, 6'd32, 1'b1));
    send_item(make_item(ReqPin,     '1, '1, 6'd63, 1'b0));
    send_item(make_item(ReqRead,    b + 'h04, '0, '0, 1'b0));
    send_item(make_item(ReqRead,    b + 'h20, '0, '0, 1'b0));
    send_item(make_item(ReqRead,    b + 'h3C, '0, '0, 1'b0));
    send_item(make_item(ReqRead,    b + 'h08, '0, '0, 1'b0));
    send_item(make_item(ReqRead,    b + 'h10, '0, '0, 1'b0));
    send_item(make_item(ReqWrite,   b + 'h10, 32'hFFFF_FFFF, '0, 1'b0));
    send_item(make_item(ReqRead,    b - 1, '0, '0, 1'b0));
    send_item(make_item(ReqWrite,   b + WindowBytes, 32'hFFFF_FFFF, '0, 1'b0));
    send_item(make_item(ReqRead,    b + WindowBytes - 1, '0, '0, 1'b0));
    send_item(make_item(ReqRefresh, '0, '0, '0, 1'b0));
    send_item(make_item(ReqWrite,   b + 'h28, 32'hFFFF_FFFF, '0, 1'b0));
    send_item(make_item(ReqRefresh, '0, '0, '0, 1'b0));

    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    run_random(110, -1, -1);

    // window wraps past the top of the address space
    load_config('{32'hFFFF_FFC0, 8'h00, 8'hFF, 8'h80, 8'h10, 8'hC4, 8'h7F, 8'h20});
    run_random(110, 30, -1);

    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    load_config('{32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF});
    run_random(80, -1, -1);

    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    load_config('{32'hFFFF_FFFF, 8'h40, 8'h40, 8'h41, 8'h41, 8'h42, 8'h42, 8'h40});
    run_random(90, -1, 40);

    load_config(random_config());
    run_random(70, -1, -1);
    load_config(random_config());
    run_random(70, -1, -1);

    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    load_config(DefaultCfg);
    run_random(70, -1, -1);

    drain();
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
